// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds at the same edge as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds at the next edge after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sida_pkg.sv -----
// types and constants of the search/insert/delete admission controller
package sida_pkg;

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 32;
   localparam int GRANT_BITS    = 8;
   localparam int COUNT_OUT_BITS = 16;

   typedef enum logic [2:0] {
      MODE_SEARCH_REQ  = 3'd0,
      MODE_INSERT_REQ  = 3'd1,
      MODE_DELETE_REQ  = 3'd2,
      MODE_SEARCH_DONE = 3'd3,
      MODE_INSERT_DONE = 3'd4,
      MODE_DELETE_DONE = 3'd5
   } mode_type;

   typedef struct packed {
      logic     item_removed;
      logic     insert_ok;
      mode_type mode;
   } event_type;

   typedef struct packed {
      logic [COUNT_OUT_BITS-1:0] element_count;
      logic                      delete_grant;
      logic                      insert_grant;
      logic [GRANT_BITS-1:0]     search_grants;
   } result_type;

endpackage

// ----- rtl/search_insert_delete_admission.sv -----
// top level of the search/insert/delete admission controller
//
//   channel   dir   width  content
//   req_*     in    8      one event word: mode, insert_ok, item_removed
//   rsp_*     out   32     one result word: grants and element count
//
// one event per cycle sustained while rsp_tready stays high; rsp_tvalid rises after
// the req accept once the event has passed the input register, then the grant
// logic into the result register
// every event produces exactly one result word
// reset is synchronous and clears the admission state and both valid flags
// a stalled rsp word holds; the input register still takes a word when the
// result register is being drained in the same cycle
module search_insert_delete_admission
   import sida_pkg::*;
#(
   parameter int CLIENT_COUNT_BITS  = 8,
   parameter int ELEMENT_COUNT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [2:0] mode, [3] insert_ok, [4] item_removed, [7:5] zero
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [7:0] search_grants, [8] insert_grant, [9] delete_grant,
   // [25:10] element_count, [31:26] zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int RESULT_BITS = $bits(result_type);

   logic       in_valid_ff;
   event_type  in_event_ff;
   logic       rsp_valid_ff;
   result_type rsp_result_ff;
   result_type result;
   logic       advance;
   logic       fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   sida_engine #(
      .CLIENT_COUNT_BITS  (CLIENT_COUNT_BITS),
      .ELEMENT_COUNT_BITS (ELEMENT_COUNT_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .evt    (in_event_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_event_ff.mode         <= mode_type'(req_tdata[2:0]);
         in_event_ff.insert_ok    <= req_tdata[3];
         in_event_ff.item_removed <= req_tdata[4];
      end
      if (fire) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RESULT_BITS){1'b0}}, rsp_result_ff};

endmodule

// ----- rtl/sida_engine.sv -----
// admission state registers and the per-event grant logic
module sida_engine
   import sida_pkg::*;
#(
   parameter int CLIENT_COUNT_BITS  = 8,
   parameter int ELEMENT_COUNT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  event_type  evt,
   output result_type result
);

   localparam int CW  = CLIENT_COUNT_BITS;
   localparam int EW  = ELEMENT_COUNT_BITS;
   localparam int GW  = (CW > GRANT_BITS) ? CW : GRANT_BITS;
   localparam int XW  = (EW > COUNT_OUT_BITS) ? EW : COUNT_OUT_BITS;
   localparam logic [CW-1:0] CMAX = {CW{1'b1}};
   localparam logic [EW-1:0] EMAX = {EW{1'b1}};
   localparam logic [GW-1:0] GRANT_LIMIT = GW'({GRANT_BITS{1'b1}});
   localparam logic [XW-1:0] COUNT_LIMIT = XW'({COUNT_OUT_BITS{1'b1}});

   logic [CW-1:0] searchers_active_ff, searchers_active_in;
   logic [CW-1:0] searchers_waiting_ff, searchers_waiting_in;
   logic [CW-1:0] inserters_waiting_ff, inserters_waiting_in;
   logic [CW-1:0] deleters_waiting_ff, deleters_waiting_in;
   logic          inserter_busy_ff, inserter_busy_in;
   logic          deleter_busy_ff, deleter_busy_in;
   logic          deleter_priority_ff, deleter_priority_in;
   logic [EW-1:0] stored_count_ff, stored_count_in;

   logic [CW-1:0] room;
   logic [CW-1:0] moved_room;
   logic [GW-1:0] moved_wide;
   logic [CW-1:0] moved;
   logic [XW-1:0] count_wide;
   logic [GRANT_BITS-1:0] sgrants;
   logic          igrant;
   logic          dgrant;

   // searchers released by a delete done: limited by room and by the grant field
   always_comb begin
      room       = CMAX - searchers_active_ff;
      moved_room = (searchers_waiting_ff > room) ? room : searchers_waiting_ff;
      moved_wide = GW'(moved_room);
      if (moved_wide > GRANT_LIMIT) begin
         moved_wide = GRANT_LIMIT;
      end
      moved = moved_wide[CW-1:0];
   end

   always_comb begin
      searchers_active_in  = searchers_active_ff;
      searchers_waiting_in = searchers_waiting_ff;
      inserters_waiting_in = inserters_waiting_ff;
      deleters_waiting_in  = deleters_waiting_ff;
      inserter_busy_in     = inserter_busy_ff;
      deleter_busy_in      = deleter_busy_ff;
      deleter_priority_in  = deleter_priority_ff;
      stored_count_in      = stored_count_ff;
      sgrants              = '0;
      igrant               = 1'b0;
      dgrant               = 1'b0;

      case (evt.mode)
         MODE_SEARCH_REQ: begin
            if (!deleter_busy_ff && !deleter_priority_ff && searchers_active_ff != CMAX) begin
               searchers_active_in = searchers_active_ff + 1'b1;
               sgrants             = GRANT_BITS'(1);
            end else if (searchers_waiting_ff != CMAX) begin
               searchers_waiting_in = searchers_waiting_ff + 1'b1;
            end
         end
         MODE_INSERT_REQ: begin
            if (!deleter_busy_ff && !inserter_busy_ff) begin
               inserter_busy_in = 1'b1;
               igrant           = 1'b1;
            end else if (inserters_waiting_ff != CMAX) begin
               inserters_waiting_in = inserters_waiting_ff + 1'b1;
            end
         end
         MODE_DELETE_REQ: begin
            if (searchers_active_ff == '0 && !inserter_busy_ff && !deleter_busy_ff) begin
               deleter_busy_in     = 1'b1;
               deleter_priority_in = 1'b0;
               dgrant              = 1'b1;
            end else if (deleters_waiting_ff != CMAX) begin
               deleters_waiting_in = deleters_waiting_ff + 1'b1;
            end
         end
         MODE_SEARCH_DONE: begin
            if (searchers_active_ff != '0) begin
               searchers_active_in = searchers_active_ff - 1'b1;
               if (deleters_waiting_ff != '0) begin
                  if (searchers_active_ff == CW'(1) && !inserter_busy_ff) begin
                     deleters_waiting_in = deleters_waiting_ff - 1'b1;
                     deleter_busy_in     = 1'b1;
                     deleter_priority_in = 1'b0;
                     dgrant              = 1'b1;
                  end else begin
                     deleter_priority_in = 1'b1;
                  end
               end
            end
         end
         MODE_INSERT_DONE: begin
            if (inserter_busy_ff) begin
               if (evt.insert_ok && stored_count_ff != EMAX) begin
                  stored_count_in = stored_count_ff + 1'b1;
               end
               inserter_busy_in = 1'b0;
               if (deleters_waiting_ff != '0) begin
                  if (searchers_active_ff != '0) begin
                     deleter_priority_in = 1'b1;
                  end else begin
                     deleters_waiting_in = deleters_waiting_ff - 1'b1;
                     deleter_busy_in     = 1'b1;
                     deleter_priority_in = 1'b0;
                     dgrant              = 1'b1;
                  end
               end else if (inserters_waiting_ff != '0) begin
                  inserters_waiting_in = inserters_waiting_ff - 1'b1;
                  inserter_busy_in     = 1'b1;
                  igrant               = 1'b1;
               end
            end
         end
         MODE_DELETE_DONE: begin
            if (deleter_busy_ff) begin
               if (evt.item_removed && stored_count_ff != '0) begin
                  stored_count_in = stored_count_ff - 1'b1;
               end
               deleter_busy_in = 1'b0;
               if (deleters_waiting_ff != '0) begin
                  deleters_waiting_in = deleters_waiting_ff - 1'b1;
                  deleter_busy_in     = 1'b1;
                  deleter_priority_in = 1'b0;
                  dgrant              = 1'b1;
               end else begin
                  searchers_waiting_in = searchers_waiting_ff - moved;
                  searchers_active_in  = searchers_active_ff + moved;
                  sgrants              = moved_wide[GRANT_BITS-1:0];
                  if (inserters_waiting_ff != '0) begin
                     inserters_waiting_in = inserters_waiting_ff - 1'b1;
                     inserter_busy_in     = 1'b1;
                     igrant               = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // reported count saturates at the field's maximum
   always_comb begin
      count_wide           = XW'(stored_count_in);
      result.search_grants = sgrants;
      result.insert_grant  = igrant;
      result.delete_grant  = dgrant;
      result.element_count = (count_wide > COUNT_LIMIT) ? {COUNT_OUT_BITS{1'b1}}
                                                        : count_wide[COUNT_OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         searchers_active_ff  <= '0;
         searchers_waiting_ff <= '0;
         inserters_waiting_ff <= '0;
         deleters_waiting_ff  <= '0;
         inserter_busy_ff     <= 1'b0;
         deleter_busy_ff      <= 1'b0;
         deleter_priority_ff  <= 1'b0;
         stored_count_ff      <= '0;
      end else if (fire) begin
         searchers_active_ff  <= searchers_active_in;
         searchers_waiting_ff <= searchers_waiting_in;
         inserters_waiting_ff <= inserters_waiting_in;
         deleters_waiting_ff  <= deleters_waiting_in;
         inserter_busy_ff     <= inserter_busy_in;
         deleter_busy_ff      <= deleter_busy_in;
         deleter_priority_ff  <= deleter_priority_in;
         stored_count_ff      <= stored_count_in;
      end
   end

endmodule

// ----- rtl/sida_checker.sv -----
// port-level checks of the admission controller, bound to the top level
`include "assert_macros.svh"

module sida_checker
   import sida_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic req_word;
   logic rsp_word;

   assign req_word = req_tvalid && req_tready;
   assign rsp_word = rsp_tvalid && rsp_tready;

   // a stalled result word stays valid
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped while stalled")

   // a deleter runs alone: its grant never comes with other grants
   `ASSERT_IMPLY(a_delete_alone, clock, reset, rsp_tvalid && rsp_tdata[9], rsp_tdata[8:0] == 9'd0, "delete grant with other grants")

   // padding above the element count stays zero
   `ASSERT_IMPLY(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[31:26] == 6'd0, "nonzero padding in rsp word")

   // a fresh result appears only after an accepted request, via the input and result registers
   `ASSERT_IMPLY(a_rsp_origin, clock, reset, $rose(rsp_tvalid), $past(req_word, 2), "rsp word without a request")

   // an idle output stage never blocks the input
   `ASSERT_IMPLY(a_no_block, clock, reset, !rsp_tvalid && !rsp_word, req_tready, "input blocked with empty output")

endmodule

bind search_insert_delete_admission sida_checker u_sida_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
